@@ hw/rtl/tmts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmts_pkg
// Shared types and constants of the tempo map tick to seconds engine.
// ----------------------------------------------------------------------------
package tmts_pkg;

  localparam logic [1:0] OP_TEMPO = 2'd0;
  localparam logic [1:0] OP_DELAY = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic REG_TICK_RATE     = 1'b0;
  localparam logic REG_DEFAULT_TEMPO = 1'b1;

  localparam logic [15:0] TICK_RATE_RESET     = 16'd96;
  localparam logic [30:0] DEFAULT_TEMPO_RESET = 31'd7864320;

  localparam int DIV_STEPS = 80;
  localparam int DIV_CW    = 7;

  typedef struct packed {
    logic [1:0]         op;
    logic [23:0]        event_tick;
    logic signed [31:0] event_value;
  } item_t;

  typedef struct packed {
    logic signed [63:0] seconds;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_CLEAR,
    EMIT_EMPTY,
    EMIT_FULL,
    EMIT_TIME
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  clear;
    logic  srch_init;
    logic  srch_rd;
    logic  srch_cmp;
    logic  prep;
    logic  mul;
    logic  div_step;
    logic  fin;
    logic  add;
    logic  delay;
    logic  write;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       drop;
    logic       more;
    logic       div_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/tmts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmts_ctrl
// Sequencer: dispatch, clear, search, scaling division, accumulation, delay and table write steps.
// ----------------------------------------------------------------------------
module tmts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tmts_pkg::dp_stat_t stat,
  output tmts_pkg::dp_cmd_t  cmd
);
  import tmts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SRCH_CMP,
    S_ENT_WAIT,
    S_MUL,
    S_DIV,
    S_FIN,
    S_ADD,
    S_DELAY,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.emit   = EMIT_CLEAR;
            state_next = S_IDLE;
          end
          OP_QUERY: begin
            if (stat.empty) begin
              cmd.emit   = EMIT_EMPTY;
              state_next = S_IDLE;
            end else begin
              cmd.srch_init = 1'b1;
              state_next    = S_SRCH;
            end
          end
          default: begin
            if (stat.drop) begin
              cmd.emit   = EMIT_FULL;
              state_next = S_IDLE;
            end else begin
              cmd.prep   = 1'b1;
              state_next = S_MUL;
            end
          end
        endcase
      end
      S_SRCH: begin
        if (stat.more) begin
          cmd.srch_rd = 1'b1;
          state_next  = S_SRCH_CMP;
        end else begin
          state_next = S_ENT_WAIT;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = S_SRCH;
      end
      S_ENT_WAIT: begin
        cmd.prep   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = (stat.op == OP_QUERY) ? S_EMIT : S_DELAY;
      end
      S_DELAY: begin
        cmd.delay  = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        cmd.emit   = EMIT_TIME;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit   = EMIT_TIME;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_CMP) |-> ($past(state) == S_SRCH))
    else $error("search compare without read");
  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> ($past(state) == S_DIV && $past(stat.div_last)))
    else $error("division cut short");
`endif

endmodule

@@ hw/rtl/tmts_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmts_dpath
// Entry table, running state, search pointers and restoring divider.
// ----------------------------------------------------------------------------
module tmts_dpath #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  tmts_pkg::item_t    item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  tmts_pkg::dp_cmd_t  cmd,
  output tmts_pkg::dp_stat_t stat,
  output logic               done,
  output tmts_pkg::result_t  result
);
  import tmts_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic signed [63:0] T_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] T_MIN = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? T_MIN : T_MAX;
    end
    return s[63:0];
  endfunction

  logic [23:0] tick_mem  [MAX_ENTRIES];
  logic [63:0] time_mem  [MAX_ENTRIES];
  logic [31:0] tempo_mem [MAX_ENTRIES];

  logic [15:0]        tick_rate;
  logic [30:0]        default_tempo;
  logic [CW-1:0]      count;
  logic [23:0]        last_tick;
  logic signed [63:0] running_time;
  logic [31:0]        running_tempo;

  logic [1:0]         op;
  logic [23:0]        tick;
  logic signed [31:0] value;

  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] diff;
  logic [CW-1:0] mid;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] slot;
  logic          overwrite;

  logic [23:0]        rd_tick;
  logic [63:0]        rd_time;
  logic [31:0]        rd_tempo;

  logic [23:0]        base_tick;
  logic [31:0]        base_tempo;
  logic signed [24:0] delta;
  logic [23:0]        md_c;
  logic [31:0]        mt_c;

  logic               neg;
  logic               md_zero;
  logic [31:0]        num;
  logic [31:0]        mt;
  logic signed [63:0] base_time;
  logic [47:0]        den;
  logic [79:0]        dvd;
  logic [47:0]        rem;
  logic [63:0]        quo;
  logic               ovf;
  logic [DIV_CW-1:0]  div_cnt;
  logic [48:0]        rem_sh;
  logic               zero_flag;
  logic signed [63:0] term;
  logic signed [63:0] acc;

  assign diff      = hi - lo;
  assign mid       = lo + {1'b0, diff[CW-1:1]};
  assign rd_addr   = cmd.srch_rd ? mid[AW-1:0] : lo[AW-1:0];
  assign overwrite = (count != '0) && (tick == last_tick);
  assign slot      = overwrite ? AW'(count - 1'b1) : AW'(count);

  assign stat.op       = op;
  assign stat.empty    = (count == '0);
  assign stat.drop     = !overwrite && (count >= CW'(MAX_ENTRIES));
  assign stat.more     = (diff > CW'(1));
  assign stat.div_last = (div_cnt == DIV_CW'(DIV_STEPS - 1));

  assign base_tick  = (op == OP_QUERY) ? rd_tick : last_tick;
  assign base_tempo = (op == OP_QUERY) ? rd_tempo : running_tempo;
  assign delta      = $signed({1'b0, tick}) - $signed({1'b0, base_tick});
  assign md_c       = delta[24] ? 24'(-delta) : delta[23:0];
  assign mt_c       = base_tempo[31] ? (~base_tempo + 32'd1) : base_tempo;
  assign rem_sh     = {rem, dvd[79]};

  always_ff @(posedge clk) begin
    rd_tick  <= tick_mem[rd_addr];
    rd_time  <= time_mem[rd_addr];
    rd_tempo <= tempo_mem[rd_addr];
    if (cmd.write) begin
      tick_mem[slot]  <= tick;
      time_mem[slot]  <= acc;
      tempo_mem[slot] <= (op == OP_TEMPO) ? value : running_tempo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= item.op;
      tick  <= item.event_tick;
      value <= item.event_value;
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= count;
    end
    if (cmd.srch_cmp) begin
      if (tick < rd_tick) begin
        hi <= mid;
      end else begin
        lo <= mid;
      end
    end
    if (cmd.prep) begin
      neg       <= delta[24] ^ base_tempo[31];
      md_zero   <= (md_c == '0);
      num       <= 32'(md_c) * 32'd240;
      mt        <= mt_c;
      base_time <= (op == OP_QUERY) ? rd_time : running_time;
    end
    if (cmd.mul) begin
      den     <= 48'(mt) * 48'(tick_rate);
      dvd     <= {num, 48'd0};
      rem     <= '0;
      quo     <= '0;
      ovf     <= 1'b0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      dvd     <= {dvd[78:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
      ovf     <= ovf | quo[63];
      if (rem_sh >= {1'b0, den}) begin
        rem <= 48'(rem_sh - {1'b0, den});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[47:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      zero_flag <= 1'b0;
      if (md_zero) begin
        term <= '0;
      end else if (den == '0) begin
        term      <= neg ? T_MIN : T_MAX;
        zero_flag <= 1'b1;
      end else if (neg) begin
        term <= (ovf || quo[63]) ? T_MIN : -$signed(quo);
      end else begin
        term <= (ovf || quo[63]) ? T_MAX : $signed(quo);
      end
    end
    if (cmd.add) begin
      acc <= sat_add(base_time, term);
    end
    if (cmd.delay && op == OP_DELAY) begin
      acc <= sat_add(acc, {{16{value[31]}}, value, 16'd0});
    end
    case (cmd.emit)
      EMIT_CLEAR: result <= '{seconds: '0, status: ST_OK};
      EMIT_EMPTY: result <= '{seconds: '0, status: ST_EMPTY};
      EMIT_FULL:  result <= '{seconds: '0, status: ST_FULL};
      EMIT_TIME:  result <= '{seconds: acc, status: zero_flag ? ST_ZERO : ST_OK};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate     <= TICK_RATE_RESET;
      default_tempo <= DEFAULT_TEMPO_RESET;
      count         <= '0;
      last_tick     <= '0;
      running_time  <= '0;
      running_tempo <= {1'b0, DEFAULT_TEMPO_RESET};
      done          <= 1'b0;
    end else begin
      done <= (cmd.emit != EMIT_NONE);
      if (cfg_we) begin
        if (cfg_index == REG_TICK_RATE) begin
          tick_rate <= cfg_data[15:0];
        end else begin
          default_tempo <= cfg_data;
        end
      end
      if (cmd.clear) begin
        count         <= '0;
        last_tick     <= '0;
        running_time  <= '0;
        running_tempo <= {1'b0, default_tempo};
      end
      if (cmd.write) begin
        if (!overwrite) begin
          count <= count + 1'b1;
        end
        last_tick    <= tick;
        running_time <= acc;
        if (op == OP_TEMPO) begin
          running_tempo <= value;
        end
      end
    end
  end

endmodule

@@ hw/rtl/tempo_map_tick_to_seconds_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_map_tick_to_seconds_core
// Tempo map engine converting tick positions to seconds.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy low; its one result appears on
// result with done high for a single cycle, the first cycle with busy low
// again, and cannot be held off. After acceptance busy stays high until the
// result is emitted: clear and rejected words end in the dispatch state,
// events run the 80-step restoring divider for the tick-to-time scaling, and
// queries first take binary search steps (up to the ceiling of log2 of the
// table fill) before the divider. Configuration writes are taken at any edge
// with cfg_we high but belong to idle periods.
module tempo_map_tick_to_seconds_core #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tmts_pkg::item_t   item,
  output logic              done,
  output tmts_pkg::result_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [30:0]       cfg_data
);
  import tmts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tmts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tmts_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule

@@ bench/tempo_map_tick_to_seconds_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_map_tick_to_seconds_core_test
// Self-checking bench for the tempo map engine. Words are driven from a queue
// at the falling edge and results are compared at the rising edge against a
// local model of the tempo table and running time. The run walks through
// several tick rate and default tempo settings, fills the table past its end
// and mixes random events, queries and clears.
// ----------------------------------------------------------------------------
module tempo_map_tick_to_seconds_core_test;
  import tmts_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [63:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  logic        cfg_we;
  logic        cfg_index;
  logic [30:0] cfg_data;

  tempo_map_tick_to_seconds_core #(.MAX_ENTRIES(TABLE_DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  item_t   pending_words[$];
  result_t expected_results[$];
  bit      took;
  int      gap_left;
  bit      quiet;
  int      errors;
  int      cycles;

  // local copy of the tempo table
  logic [23:0]        tick_tab[TABLE_DEPTH];
  logic signed [63:0] time_tab[TABLE_DEPTH];
  logic [31:0]        tempo_tab[TABLE_DEPTH];
  int                 n_entries;
  logic [23:0]        prev_tick;
  logic signed [63:0] run_time;
  logic [31:0]        run_tempo;
  logic [15:0]        tick_rate_q;
  logic [30:0]        default_tempo_q;
  logic [23:0]        gen_tick;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? T_MIN : T_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ticks_to_time(logic signed [63:0] delta,
                                                       logic [31:0] tempo,
                                                       output bit zero);
    logic [63:0]  md;
    logic [31:0]  mt;
    logic [63:0]  den;
    logic [127:0] q;
    bit           neg;
    zero = 0;
    neg = delta < 0;
    md = neg ? -delta : delta;
    if (tempo[31]) begin
      mt = -tempo;
      neg = !neg;
    end else begin
      mt = tempo;
    end
    if (md == 0) return 0;
    den = {32'd0, mt} * {48'd0, tick_rate_q};
    if (den == 0) begin
      zero = 1;
      return neg ? T_MIN : T_MAX;
    end
    q = ({64'd0, md * 64'd240} << 48) / {64'd0, den};
    if (neg) begin
      if (q[127:63] != 0) return T_MIN;
      return -$signed(q[63:0]);
    end
    if (q[127:63] != 0) return T_MAX;
    return $signed(q[63:0]);
  endfunction

  function automatic result_t apply_word(item_t w);
    result_t            r;
    logic signed [63:0] delta;
    logic signed [63:0] val64;
    bit                 zero;
    bit                 overwrite;
    int                 lo, hi, mid, slot;
    r.seconds = 0;
    r.status = ST_OK;
    zero = 0;
    case (w.op)
      OP_CLEAR: begin
        n_entries = 0;
        prev_tick = 0;
        run_time = 0;
        run_tempo = {1'b0, default_tempo_q};
      end
      OP_QUERY: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = 0;
          hi = n_entries;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (w.event_tick < tick_tab[mid]) hi = mid;
            else lo = mid;
          end
          delta = $signed({40'd0, w.event_tick}) - $signed({40'd0, tick_tab[lo]});
          r.seconds = sat_sum(time_tab[lo], ticks_to_time(delta, tempo_tab[lo], zero));
          if (zero) r.status = ST_ZERO;
        end
      end
      default: begin
        delta = $signed({40'd0, w.event_tick}) - $signed({40'd0, prev_tick});
        overwrite = n_entries > 0 && delta == 0;
        if (!overwrite && n_entries >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          run_time = sat_sum(run_time, ticks_to_time(delta, run_tempo, zero));
          prev_tick = w.event_tick;
          if (w.op == OP_TEMPO) begin
            run_tempo = w.event_value;
          end else begin
            val64 = w.event_value;
            run_time = sat_sum(run_time, val64 <<< 16);
          end
          if (overwrite) begin
            slot = n_entries - 1;
          end else begin
            slot = n_entries;
            n_entries = n_entries + 1;
          end
          tick_tab[slot] = w.event_tick;
          time_tab[slot] = run_time;
          tempo_tab[slot] = run_tempo;
          r.seconds = run_time;
          if (zero) r.status = ST_ZERO;
        end
      end
    endcase
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (took) begin
        void'(pending_words.pop_front());
        took = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else if (pending_words.size() == 0) begin
        start <= 0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        gap_left = $urandom_range(1, 16) - 1;
        start <= 0;
      end else begin
        start <= 1;
        item <= pending_words[0];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %h", result);
        end else begin
          want = expected_results.pop_front();
          if (result.seconds !== want.seconds || result.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: seconds %h status %0d, expected %h status %0d",
                       result.seconds, result.status, want.seconds, want.status);
          end
        end
      end
      if (start && !busy) begin
        took = 1;
        expected_results.push_back(apply_word(item));
      end
    end
  end

  task automatic push_word(logic [1:0] op, logic [23:0] tk, logic [31:0] v);
    item_t w;
    w.op = op;
    w.event_tick = tk;
    w.event_value = v;
    pending_words.push_back(w);
  endtask

  task automatic push_random();
    logic [1:0]  op;
    logic [31:0] v;
    logic [23:0] tk;
    int          pick;
    pick = $urandom_range(0, 99);
    op = pick < 40 ? OP_TEMPO : pick < 60 ? OP_DELAY : pick < 97 ? OP_QUERY : OP_CLEAR;
    pick = $urandom_range(0, 9);
    if (pick < 6) gen_tick = gen_tick + 24'($urandom_range(1, 400));
    else if (pick == 6) gen_tick = gen_tick;
    else if (pick == 7) gen_tick = gen_tick - 24'($urandom_range(1, 400));
    else gen_tick = 24'($urandom());
    tk = gen_tick;
    if (op == OP_QUERY) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) tk = 24'($urandom());
      else if (pick == 1) tk = gen_tick - 24'($urandom_range(0, 2000));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) v = $urandom_range(32'h0010_0000, 32'h0140_0000);
    else if (pick == 6) v = 0;
    else if (pick == 7) v = -$urandom_range(1, 32'h0100_0000);
    else v = $urandom();
    if (op == OP_CLEAR) gen_tick = 0;
    push_word(op, tk, v);
  endtask

  task automatic write_reg(logic idx, logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == REG_TICK_RATE) tick_rate_q = v[15:0];
    else default_tempo_q = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_results.size() == 0 && !start);
    repeat (200) @(negedge clk);
  endtask

  task automatic random_phase(logic [15:0] tr, logic [30:0] dt, int count);
    write_reg(REG_TICK_RATE, {15'd0, tr});
    write_reg(REG_DEFAULT_TEMPO, dt);
    push_word(OP_CLEAR, 0, 0);
    gen_tick = 0;
    repeat (count) push_random();
    drain();
  endtask

  initial begin
    int i;
    start = 0;
    item = '0;
    cfg_we = 0;
    cfg_index = REG_TICK_RATE;
    cfg_data = 0;
    took = 0;
    gap_left = 0;
    quiet = 0;
    errors = 0;
    cycles = 0;
    tick_rate_q = TICK_RATE_RESET;
    default_tempo_q = DEFAULT_TEMPO_RESET;
    n_entries = 0;
    prev_tick = 0;
    run_time = 0;
    run_tempo = {1'b0, DEFAULT_TEMPO_RESET};
    rst = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed words under reset settings
    push_word(OP_QUERY, 24'd10, 0);
    push_word(OP_TEMPO, 24'd0, 32'h0078_0000);
    push_word(OP_TEMPO, 24'd0, 32'h00B4_0000);
    push_word(OP_DELAY, 24'd96, 32'h0001_8000);
    push_word(OP_QUERY, 24'd50, 0);
    push_word(OP_TEMPO, 24'd192, 32'h0000_0000);
    push_word(OP_DELAY, 24'd300, 32'hFFFF_0000);
    push_word(OP_QUERY, 24'd192, 0);
    push_word(OP_QUERY, 24'd500, 0);
    push_word(OP_TEMPO, 24'd400, 32'hFF88_0000);
    push_word(OP_DELAY, 24'd350, 32'h7FFF_FFFF);
    push_word(OP_QUERY, 24'd0, 0);
    push_word(OP_TEMPO, 24'hFFFFFF, 32'h8000_0000);
    push_word(OP_QUERY, 24'hFFFFFF, 0);
    push_word(OP_DELAY, 24'd5, 32'h8000_0000);
    push_word(OP_TEMPO, 24'd6, 32'h0000_0001);
    push_word(OP_QUERY, 24'hFFFFFF, 0);
    push_word(OP_CLEAR, 24'hFFFFFF, 32'hFFFF_FFFF);
    push_word(OP_TEMPO, 24'd20, 32'h0078_0000);
    push_word(OP_QUERY, 24'd3, 0);
    push_word(OP_CLEAR, 0, 0);
    drain();

    // fill the table past its end
    write_reg(REG_TICK_RATE, {15'd0, 16'd480});
    write_reg(REG_DEFAULT_TEMPO, 31'h0050_0000);
    push_word(OP_CLEAR, 0, 0);
    for (i = 0; i < TABLE_DEPTH + 8; i++) begin
      push_word(i % 3 == 0 ? OP_DELAY : OP_TEMPO, 24'(i * 37 + 1),
                $urandom_range(32'h0010_0000, 32'h0100_0000));
      if (i % 16 == 0) push_word(OP_QUERY, 24'($urandom_range(0, i * 37 + 50)), 0);
    end
    push_word(OP_TEMPO, 24'((TABLE_DEPTH - 1) * 37 + 1), 32'h0064_0000);
    for (i = 0; i < 8; i++) push_word(OP_QUERY, 24'($urandom_range(0, 24'h00FFFF)), 0);
    drain();

    random_phase(16'd1, 31'd1, 220);
    random_phase(16'hFFFF, 31'h7FFF_FFFF, 220);
    random_phase(16'd0, 31'd7864320, 120);
    random_phase(TICK_RATE_RESET, DEFAULT_TEMPO_RESET, 380);
    random_phase(16'($urandom_range(1, 65535)), 31'($urandom_range(1, 31'h7FFF_FFFF)), 220);
    random_phase(16'($urandom_range(24, 960)),
                 31'($urandom_range(31'h0028_0000, 31'h012C_0000)), 220);
    quiet = 1;
    random_phase(16'd192, 31'h0078_0000, 200);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
